### hdl/rtmp_chunk_deframer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunk deframer.
// Shared property templates used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RTMP_CHUNK_DEFRAMER_UNIT_ASSERT_SVH
`define RTMP_CHUNK_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define RCD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication under reset.
`define RCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### hdl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Types, constants and helper functions shared by the chunk deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcd_pkg;

    localparam int CONTEXT_COUNT_DEF = 64;

    localparam logic [23:0] MAX24         = 24'hFFFFFF;
    localparam logic [23:0] DEFAULT_CHUNK = 24'd128;
    localparam logic [7:0]  TYPE_SET_CHUNK = 8'd1;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BODY      = 2'd1;
    localparam logic [1:0] ERR_ID        = 2'd2;
    localparam logic [1:0] ERR_SET_CHUNK = 2'd3;

    localparam logic [1:0] FMT_FULL  = 2'd0;
    localparam logic [1:0] FMT_BARE  = 2'd3;

    typedef struct packed {
        logic [23:0] stamp_field;
        logic [31:0] msg_time;
        logic [23:0] body_len;
        logic [23:0] received;
        logic        abs_time;
        logic [7:0]  msg_type;
        logic [31:0] msg_stream;
    } ctx_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [16:0] chunk_stream_id;
        logic [7:0]  message_type;
        logic [31:0] message_stream_id;
        logic [23:0] message_length;
        logic [31:0] message_timestamp;
        logic        last_of_message;
        logic [1:0]  error_code;
    } out_t;

    typedef struct packed {
        logic [1:0] error_code;
        logic       loading;
        logic       byte_taken;
    } status_t;

    // Number of message header bytes for each fmt.
    function automatic logic [3:0] hdr_last(input logic [1:0] fmt);
        logic [3:0] r;
        unique case (fmt)
            2'd0: r = 4'd11;
            2'd1: r = 4'd7;
            2'd2: r = 4'd3;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] clamp24(input logic [23:0] v);
        return (v == 24'd0) ? 24'd1 : v;
    endfunction

    function automatic logic [23:0] clamp32(input logic [31:0] v);
        logic [23:0] r;
        if (v == 32'd0)
        begin
            r = 24'd1;
        end
        else if (v[31:24] != 8'd0)
        begin
            r = MAX24;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/rcd_queue.sv
// ----------------------------------------------------------------------------
// rcd_queue
// Two-entry queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [WIDTH-1:0] in_data,
    output      logic             full,
    output      logic             out_valid,
    output      logic [WIDTH-1:0] out_data,
    input  wire logic             out_stall
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && !full;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

### hdl/rcd_ctx_mem.sv
// ----------------------------------------------------------------------------
// rcd_ctx_mem
// Per chunk stream context memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_ctx_mem #(
    parameter int CONTEXT_COUNT = rcd_pkg::CONTEXT_COUNT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(CONTEXT_COUNT)-1:0] wr_idx,
    input  wire rcd_pkg::ctx_t                    wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(CONTEXT_COUNT)-1:0] rd_idx,
    output      rcd_pkg::ctx_t                    rd_data,
    output      logic                             busy
);

    localparam int IW = $clog2(CONTEXT_COUNT);

    rcd_pkg::ctx_t   mem [CONTEXT_COUNT];
    logic [IW-1:0]   clr_idx_reg;
    logic            clr_busy_reg;

    assign busy = clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == IW'(CONTEXT_COUNT - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_idx];
        end
    end

endmodule

`default_nettype wire

### hdl/rcd_parser.sv
// ----------------------------------------------------------------------------
// rcd_parser
// Back end: parses chunk headers, tracks contexts and produces payload beats.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_parser #(
    parameter int CONTEXT_COUNT = rcd_pkg::CONTEXT_COUNT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             byte_valid,
    input  wire logic [7:0]                       byte_data,
    output      logic                             byte_pop,
    input  wire logic                             cfg_we,
    input  wire logic [23:0]                      cfg_size,
    input  wire logic                             out_full,
    output      logic                             out_push,
    output      rcd_pkg::out_t                    out_word,
    output      logic                             mem_wr_en,
    output      logic [$clog2(CONTEXT_COUNT)-1:0] mem_wr_idx,
    output      rcd_pkg::ctx_t                    mem_wr_data,
    output      logic                             mem_rd_en,
    output      logic [$clog2(CONTEXT_COUNT)-1:0] mem_rd_idx,
    input  wire rcd_pkg::ctx_t                    mem_rd_data,
    input  wire logic                             mem_busy,
    output      rcd_pkg::status_t                 status
);

    localparam int IW = $clog2(CONTEXT_COUNT);

    typedef enum logic [2:0] {
        PH_BASIC0,
        PH_TWO1,
        PH_THREE1,
        PH_THREE2,
        PH_LOAD,
        PH_MSGHDR,
        PH_EXTTS,
        PH_PAYLOAD
    } phase_t;

    phase_t        phase_reg,  phase_next;
    logic [3:0]    hcnt_reg,   hcnt_next;
    logic [1:0]    fmt_reg,    fmt_next;
    logic [16:0]   csid_reg,   csid_next;
    logic [31:0]   shift_reg,  shift_next;
    logic [23:0]   left_reg,   left_next;
    logic [23:0]   size_reg,   size_next;
    logic [31:0]   cap_reg,    cap_next;
    logic [1:0]    err_reg,    err_next;
    logic [31:0]   ctime_reg,  ctime_next;
    rcd_pkg::ctx_t ctx_reg,    ctx_next;
    logic          live_reg,   live_next;
    logic [IW-1:0] cidx_reg,   cidx_next;

    logic proc;
    logic load_go;

    assign proc    = byte_valid && !out_full && !mem_busy && (phase_reg != PH_LOAD);
    assign load_go = (phase_reg == PH_LOAD) && !out_full;

    assign mem_wr_en   = live_reg;
    assign mem_wr_idx  = cidx_reg;
    assign mem_wr_data = ctx_reg;

    assign status.error_code = err_reg;
    assign status.loading    = (phase_reg == PH_LOAD);
    assign status.byte_taken = proc;

    always_comb
    begin
        logic        hd;
        logic        cs;
        logic        cm;
        logic        cm_emit;
        logic        idk;
        logic        raise;
        logic [1:0]  rcode;
        logic [16:0] new_id;
        logic [23:0] rem;
        logic [23:0] more;
        logic [31:0] tsum;
        logic [23:0] rb;

        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        fmt_next   = fmt_reg;
        csid_next  = csid_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        size_next  = size_reg;
        cap_next   = cap_reg;
        err_next   = err_reg;
        ctime_next = ctime_reg;
        ctx_next   = ctx_reg;
        live_next  = live_reg;
        cidx_next  = cidx_reg;
        out_push   = 1'b0;
        out_word   = '0;
        mem_rd_en  = 1'b0;
        mem_rd_idx = csid_reg[IW-1:0];
        byte_pop   = 1'b0;
        hd = 1'b0; cs = 1'b0; cm = 1'b0; cm_emit = 1'b0; idk = 1'b0;
        raise = 1'b0; rcode = rcd_pkg::ERR_NONE;
        new_id = csid_reg;
        rem = '0; more = '0; tsum = '0; rb = '0;

        if (load_go)
        begin
            phase_next = PH_BASIC0;
            live_next  = 1'b1;
            cidx_next  = csid_reg[IW-1:0];
            if (!(live_reg && (cidx_reg == csid_reg[IW-1:0])))
            begin
                ctx_next = mem_rd_data;
            end
            if (ctx_next.received == 24'd0)
            begin
                ctx_next.abs_time = 1'b0;
            end
            hcnt_next  = 4'd0;
            shift_next = 32'd0;
            if (fmt_reg == rcd_pkg::FMT_BARE)
            begin
                hd = 1'b1;
            end
            else
            begin
                phase_next = PH_MSGHDR;
            end
        end
        else if (proc)
        begin
            byte_pop = 1'b1;
            if (err_reg != rcd_pkg::ERR_NONE)
            begin
                out_push            = 1'b1;
                out_word.error_code = err_reg;
            end
            else
            begin
                unique case (phase_reg)
                    PH_BASIC0:
                    begin
                        fmt_next = byte_data[7:6];
                        if (byte_data[5:0] == 6'd0)
                        begin
                            phase_next = PH_TWO1;
                        end
                        else if (byte_data[5:0] == 6'd1)
                        begin
                            phase_next = PH_THREE1;
                        end
                        else
                        begin
                            new_id = {11'd0, byte_data[5:0]};
                            idk    = 1'b1;
                        end
                    end
                    PH_TWO1:
                    begin
                        new_id = 17'd64 + {9'd0, byte_data};
                        idk    = 1'b1;
                    end
                    PH_THREE1:
                    begin
                        shift_next = {24'd0, byte_data};
                        phase_next = PH_THREE2;
                    end
                    PH_THREE2:
                    begin
                        new_id = 17'd64 + {1'b0, byte_data, shift_reg[7:0]};
                        idk    = 1'b1;
                    end
                    PH_MSGHDR:
                    begin
                        shift_next = {shift_reg[23:0], byte_data};
                        if (hcnt_reg == 4'd2)
                        begin
                            ctx_next.stamp_field = shift_next[23:0];
                        end
                        else if (hcnt_reg == 4'd5)
                        begin
                            ctx_next.body_len = shift_next[23:0];
                        end
                        else if (hcnt_reg == 4'd6)
                        begin
                            ctx_next.msg_type = shift_next[7:0];
                        end
                        else if (hcnt_reg == 4'd10)
                        begin
                            ctx_next.msg_stream = {shift_next[7:0], shift_next[15:8],
                                                   shift_next[23:16], shift_next[31:24]};
                        end
                        hcnt_next = hcnt_reg + 4'd1;
                        if (hcnt_next >= rcd_pkg::hdr_last(fmt_reg))
                        begin
                            hd = 1'b1;
                        end
                    end
                    PH_EXTTS:
                    begin
                        shift_next = {shift_reg[23:0], byte_data};
                        hcnt_next  = hcnt_reg + 4'd1;
                        if (hcnt_next >= 4'd4)
                        begin
                            ctime_next = shift_next;
                            cs         = 1'b1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        rb = ctx_reg.received;
                        if (rb == 24'd0)
                        begin
                            cap_next = {24'd0, byte_data};
                        end
                        else if (rb < 24'd4)
                        begin
                            cap_next = {cap_reg[23:0], byte_data};
                        end
                        ctx_next.received = rb + 24'd1;
                        left_next         = left_reg - 24'd1;
                        if (ctx_next.received == ctx_reg.body_len)
                        begin
                            cm      = 1'b1;
                            cm_emit = 1'b1;
                        end
                        else
                        begin
                            if (left_next == 24'd0)
                            begin
                                phase_next = PH_BASIC0;
                            end
                            if (ctx_reg.msg_type != rcd_pkg::TYPE_SET_CHUNK)
                            begin
                                out_push                   = 1'b1;
                                out_word.payload_byte      = byte_data;
                                out_word.chunk_stream_id   = csid_reg;
                                out_word.message_type      = ctx_reg.msg_type;
                                out_word.message_stream_id = ctx_reg.msg_stream;
                                out_word.message_length    = ctx_reg.body_len;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_BASIC0;
                    end
                endcase
            end
        end

        if (idk)
        begin
            csid_next = new_id;
            if (new_id >= 17'(CONTEXT_COUNT))
            begin
                raise = 1'b1;
                rcode = rcd_pkg::ERR_ID;
            end
            else
            begin
                mem_rd_en  = 1'b1;
                mem_rd_idx = new_id[IW-1:0];
                phase_next = PH_LOAD;
            end
        end

        if (hd)
        begin
            if (fmt_reg == rcd_pkg::FMT_FULL)
            begin
                ctx_next.abs_time = 1'b1;
            end
            if (ctx_next.stamp_field == rcd_pkg::MAX24)
            begin
                phase_next = PH_EXTTS;
                hcnt_next  = 4'd0;
                shift_next = 32'd0;
            end
            else
            begin
                ctime_next = {8'd0, ctx_next.stamp_field};
                cs         = 1'b1;
            end
        end

        if (cs)
        begin
            if (ctx_next.body_len < ctx_next.received)
            begin
                raise = 1'b1;
                rcode = rcd_pkg::ERR_BODY;
            end
            else
            begin
                rem  = ctx_next.body_len - ctx_next.received;
                more = (rem < size_reg) ? rem : size_reg;
                if (more == 24'd0)
                begin
                    cm = 1'b1;
                end
                else
                begin
                    left_next  = more;
                    phase_next = PH_PAYLOAD;
                end
            end
        end

        if (cm)
        begin
            tsum = ctime_next + (ctx_next.abs_time ? 32'd0 : ctx_next.msg_time);
            ctx_next.msg_time = tsum;
            ctx_next.received = 24'd0;
            phase_next        = PH_BASIC0;
            if (ctx_next.msg_type == rcd_pkg::TYPE_SET_CHUNK)
            begin
                if (ctx_next.body_len == 24'd0)
                begin
                    size_next = size_reg;
                end
                else if (ctx_next.body_len < 24'd4)
                begin
                    raise = 1'b1;
                    rcode = rcd_pkg::ERR_SET_CHUNK;
                end
                else
                begin
                    size_next = rcd_pkg::clamp32(cap_next);
                end
            end
            else if (cm_emit)
            begin
                out_push                   = 1'b1;
                out_word.payload_byte      = byte_data;
                out_word.chunk_stream_id   = csid_reg;
                out_word.message_type      = ctx_next.msg_type;
                out_word.message_stream_id = ctx_next.msg_stream;
                out_word.message_length    = ctx_next.body_len;
                out_word.message_timestamp = tsum;
                out_word.last_of_message   = 1'b1;
            end
        end

        if (raise)
        begin
            err_next            = rcode;
            out_push            = 1'b1;
            out_word            = '0;
            out_word.error_code = rcode;
        end

        if (cfg_we)
        begin
            size_next = rcd_pkg::clamp24(cfg_size);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BASIC0;
            hcnt_reg  <= 4'd0;
            fmt_reg   <= 2'd0;
            csid_reg  <= 17'd0;
            shift_reg <= 32'd0;
            left_reg  <= 24'd0;
            size_reg  <= rcd_pkg::DEFAULT_CHUNK;
            cap_reg   <= 32'd0;
            err_reg   <= rcd_pkg::ERR_NONE;
            ctime_reg <= 32'd0;
            ctx_reg   <= '0;
            live_reg  <= 1'b0;
            cidx_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            fmt_reg   <= fmt_next;
            csid_reg  <= csid_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            size_reg  <= size_next;
            cap_reg   <= cap_next;
            err_reg   <= err_next;
            ctime_reg <= ctime_next;
            ctx_reg   <= ctx_next;
            live_reg  <= live_next;
            cidx_reg  <= cidx_next;
        end
    end

endmodule

`default_nettype wire

### hdl/rtmp_chunk_deframer_unit.sv
// ----------------------------------------------------------------------------
// rtmp_chunk_deframer_unit
// Chunk stream deframer: splits an inbound chunk stream into tagged payload.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and gives at most one payload beat
// per cycle while the output queue has room. After each chunk basic header no
// byte is taken while the context of its chunk stream id is read from the
// context memory; all other bytes pass at one per cycle. After reset no byte
// is taken until the context memory is cleared. Input bytes wait in a
// two-entry queue in front of the parser and results in a two-entry queue
// behind it, so either side may stall without stopping the other at once.
`default_nettype none

`include "rtmp_chunk_deframer_unit_assert.svh"

module rtmp_chunk_deframer_unit #(
    parameter int CONTEXT_COUNT = rcd_pkg::CONTEXT_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [23:0] initial_chunk_size,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [7:0]  byte_value,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [7:0]  payload_byte,
    output      logic [16:0] chunk_stream_id,
    output      logic [7:0]  message_type,
    output      logic [31:0] message_stream_id,
    output      logic [23:0] message_length,
    output      logic [31:0] message_timestamp,
    output      logic        last_of_message,
    output      logic [1:0]  error_code
);

    localparam int IW = $clog2(CONTEXT_COUNT);

    logic             q_valid;
    logic [7:0]       q_byte;
    logic             q_pop;
    logic             out_full;
    logic             out_push;
    rcd_pkg::out_t    push_word;
    rcd_pkg::out_t    head_word;
    logic             mem_wr_en;
    logic [IW-1:0]    mem_wr_idx;
    rcd_pkg::ctx_t    mem_wr_data;
    logic             mem_rd_en;
    logic [IW-1:0]    mem_rd_idx;
    rcd_pkg::ctx_t    mem_rd_data;
    logic             mem_busy;
    rcd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    rcd_queue #(
        .WIDTH(8)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (byte_value),
        .full      (in_stall),
        .out_valid (q_valid),
        .out_data  (q_byte),
        .out_stall (!q_pop)
    );

    rcd_ctx_mem #(
        .CONTEXT_COUNT(CONTEXT_COUNT)
    ) u_ctx (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_idx  (mem_rd_idx),
        .rd_data (mem_rd_data),
        .busy    (mem_busy)
    );

    rcd_parser #(
        .CONTEXT_COUNT(CONTEXT_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (q_valid),
        .byte_data   (q_byte),
        .byte_pop    (q_pop),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_size    (initial_chunk_size),
        .out_full    (out_full),
        .out_push    (out_push),
        .out_word    (push_word),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_idx  (mem_wr_idx),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_idx  (mem_rd_idx),
        .mem_rd_data (mem_rd_data),
        .mem_busy    (mem_busy),
        .status      (status)
    );

    rcd_queue #(
        .WIDTH($bits(rcd_pkg::out_t))
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (out_push),
        .in_data   (push_word),
        .full      (out_full),
        .out_valid (out_valid),
        .out_data  (head_word),
        .out_stall (out_stall)
    );

    assign payload_byte      = head_word.payload_byte;
    assign chunk_stream_id   = head_word.chunk_stream_id;
    assign message_type      = head_word.message_type;
    assign message_stream_id = head_word.message_stream_id;
    assign message_length    = head_word.message_length;
    assign message_timestamp = head_word.message_timestamp;
    assign last_of_message   = head_word.last_of_message;
    assign error_code        = head_word.error_code;

    `RCD_ASSERT_NOW(a_no_byte_while_clearing, mem_busy, !status.byte_taken)
    `RCD_ASSERT_NOW(a_no_push_when_full, out_push, !out_full)
    `RCD_ASSERT_NEXT(a_error_sticky, status.error_code != rcd_pkg::ERR_NONE,
                     status.error_code == $past(status.error_code))
    `RCD_ASSERT_NEXT(a_load_one_cycle, status.loading && !out_full, !status.loading)

endmodule

`default_nettype wire
